// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the device access gate.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DAG_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("device access gate assertion failed");
`define DAG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("device access gate assertion failed");
`else
`define DAG_ASSERT_IMPL(label, pre, post)
`define DAG_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/dag_pkg.sv
// Types and constants of the device access gate.
`default_nettype none
package dag_pkg;

    typedef enum logic [2:0]
    {
        CMD_CHECK   = 3'd0,
        CMD_RESERVE = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_MARK    = 3'd3,
        CMD_UNMARK  = 3'd4,
        CMD_BIND    = 3'd5,
        CMD_UNBIND  = 3'd6,
        CMD_NONE    = 3'd7
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_WRITE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0]
    {
        TBL_DEV,
        TBL_MAJ,
        TBL_NS
    } tbl_t;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_ABSENT = 2'd2;

    localparam logic [15:0] CHAR_DEVICE  = 16'd2;
    localparam logic [11:0] SHARED_MAJOR = 12'd195;
    localparam logic [19:0] SHARED_MINOR = 20'd255;

    localparam logic ADDR_MANAGED_MAJOR = 1'b0;
    localparam logic ADDR_HOST_MNT_NS   = 1'b1;

endpackage
`default_nettype wire

// File: rtl/dag_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module dag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/device_access_gate.sv
// Top level of the device access gate: sequencer, table scan unit and register port.
//
// Input words arrive on s_tvalid/s_tready/s_tdata; each gives exactly one result
// word on m_tvalid/m_tready/m_tdata. The two registers sit on the APB-style port.
// After reset a clearing pass writes every table entry invalid, one entry of each
// table per cycle; s_tready stays low meanwhile while register writes are taken.
// One item at a time is processed. A check that is decided from the device type,
// numbers and managed major alone, and a CMD_NONE item, go from the dispatch step
// straight to the result step. Otherwise one shared compare unit scans the tables
// one entry per cycle from entry 0, stopping at the first match: a check scans the
// device table and then, unless a device entry decides it, the namespace or the
// major table; a table command scans its own table. The next item is taken in the
// cycle after the result is loaded.
// The result sits in an output register; s_tready rises again once the result is
// loaded, so a stalled receiver holds only the word in that register and the next
// item waits in its last step until the register frees.
`default_nettype none
`include "assert_macros.svh"
module device_access_gate #(
    parameter int DEV_ENTRIES   = 256,
    parameter int MAJOR_ENTRIES = 256,
    parameter int NS_ENTRIES    = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd[2:0], dev_type[18:3], major[30:19], minor[50:31], mnt_ns[82:51],
    // group_id[146:83], zero fill above.
    input  wire logic [151:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // allow[0], status[2:1], zero fill above.
    output logic      [7:0]   m_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);
    localparam int MAXD0 = (DEV_ENTRIES > MAJOR_ENTRIES) ? DEV_ENTRIES : MAJOR_ENTRIES;
    localparam int MAXD  = (MAXD0 > NS_ENTRIES) ? MAXD0 : NS_ENTRIES;
    localparam int CW    = $clog2(MAXD + 1);
    localparam int AD    = (DEV_ENTRIES > 1) ? $clog2(DEV_ENTRIES) : 1;
    localparam int AM    = (MAJOR_ENTRIES > 1) ? $clog2(MAJOR_ENTRIES) : 1;
    localparam int AN    = (NS_ENTRIES > 1) ? $clog2(NS_ENTRIES) : 1;
    localparam logic [CW-1:0] DEV_LEN = CW'(DEV_ENTRIES);
    localparam logic [CW-1:0] MAJ_LEN = CW'(MAJOR_ENTRIES);
    localparam logic [CW-1:0] NS_LEN  = CW'(NS_ENTRIES);
    localparam logic [CW-1:0] CLR_LAST = CW'(MAXD - 1);

    dag_pkg::state_t state_reg, state_next;
    dag_pkg::tbl_t   tbl_reg, tbl_next;
    dag_pkg::cmd_t   cmd_reg, cmd_next;

    logic [11:0] managed_major_reg;
    logic [31:0] host_mnt_ns_reg;

    logic [15:0] type_reg, type_next;
    logic [11:0] major_reg, major_next;
    logic [19:0] minor_reg, minor_next;
    logic [31:0] ns_reg, ns_next;
    logic [63:0] group_reg, group_next;

    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          free_found_reg, free_found_next;
    logic [CW-1:0] free_idx_reg, free_idx_next;
    logic          d_found_reg, d_found_next;
    logic [63:0]   d_owner_reg, d_owner_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic          wr_zero_reg, wr_zero_next;
    logic          res_allow_reg, res_allow_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          out_allow_reg, out_allow_next;
    logic [1:0]    out_status_reg, out_status_next;

    logic [96:0] dev_rdata, ns_rdata;
    logic [76:0] maj_rdata;
    logic        dev_we, maj_we, ns_we;
    logic [96:0] dev_wdata, ns_wdata;
    logic [76:0] maj_wdata;
    logic [CW-1:0] wr_addr;

    logic [32:0]   sel_key, tgt_key;
    logic [63:0]   sel_owner, own_tgt;
    logic          sel_valid, key_eq, owner_eq, with_owner;
    logic          hit, last_entry, scan_end, free_avail, container, early_allow;
    logic          is_insert, is_remove;
    logic [CW-1:0] scan_len, free_any_idx;
    logic          in_accept, cfg_write;
    logic          any_we, wr_phase, scan_cmp;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == dag_pkg::ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_major_reg <= '0;
            host_mnt_ns_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                dag_pkg::ADDR_MANAGED_MAJOR: managed_major_reg <= pwdata[11:0];
                dag_pkg::ADDR_HOST_MNT_NS:   host_mnt_ns_reg   <= pwdata;
                default:                     host_mnt_ns_reg   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            dag_pkg::ADDR_MANAGED_MAJOR: prdata = {20'd0, managed_major_reg};
            default:                     prdata = host_mnt_ns_reg;
        endcase
    end

    // Shared compare unit over the word read from the table being scanned.
    always_comb
    begin
        case (tbl_reg)
            dag_pkg::TBL_DEV:
            begin
                sel_key   = dev_rdata[96:64];
                sel_owner = dev_rdata[63:0];
                sel_valid = dev_rdata[96];
                tgt_key   = {1'b1, major_reg, minor_reg};
                scan_len  = DEV_LEN;
            end
            dag_pkg::TBL_MAJ:
            begin
                sel_key   = {20'd0, maj_rdata[76:64]};
                sel_owner = maj_rdata[63:0];
                sel_valid = maj_rdata[76];
                tgt_key   = {20'd0, 1'b1, major_reg};
                scan_len  = MAJ_LEN;
            end
            default:
            begin
                sel_key   = ns_rdata[96:64];
                sel_owner = ns_rdata[63:0];
                sel_valid = ns_rdata[96];
                tgt_key   = {1'b1, ns_reg};
                scan_len  = NS_LEN;
            end
        endcase
    end

    assign own_tgt    = (tbl_reg == dag_pkg::TBL_NS && cmd_reg == dag_pkg::CMD_CHECK)
                        ? d_owner_reg : group_reg;
    assign with_owner = (tbl_reg == dag_pkg::TBL_MAJ);
    assign key_eq     = (sel_key == tgt_key);
    assign owner_eq   = (sel_owner == own_tgt);
    assign hit        = cmp_vld_reg && key_eq && (!with_owner || owner_eq);
    assign last_entry = cmp_vld_reg && (cmp_idx_reg == scan_len - CW'(1));
    assign scan_end   = hit || last_entry;
    assign free_avail = free_found_reg || (cmp_vld_reg && !sel_valid);
    assign free_any_idx = free_found_reg ? free_idx_reg : cmp_idx_reg;
    assign container  = (host_mnt_ns_reg == 32'd0) || (ns_reg != host_mnt_ns_reg);
    assign early_allow = (type_reg != dag_pkg::CHAR_DEVICE)
        || (major_reg == dag_pkg::SHARED_MAJOR && minor_reg == dag_pkg::SHARED_MINOR)
        || (major_reg != dag_pkg::SHARED_MAJOR
            && (managed_major_reg == 12'd0 || major_reg != managed_major_reg));
    assign is_insert = (cmd_reg inside {dag_pkg::CMD_RESERVE, dag_pkg::CMD_MARK,
                                        dag_pkg::CMD_BIND});
    assign is_remove = (cmd_reg inside {dag_pkg::CMD_RELEASE, dag_pkg::CMD_UNMARK,
                                        dag_pkg::CMD_UNBIND});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dag_pkg::ST_CLEAR:
            begin
                if (issue_reg == CLR_LAST)
                begin
                    state_next = dag_pkg::ST_IDLE;
                end
            end
            dag_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = dag_pkg::ST_DISPATCH;
                end
            end
            dag_pkg::ST_DISPATCH:
            begin
                if (cmd_reg == dag_pkg::CMD_NONE
                    || (cmd_reg == dag_pkg::CMD_CHECK && early_allow))
                begin
                    state_next = dag_pkg::ST_RESP;
                end
                else
                begin
                    state_next = dag_pkg::ST_SCAN;
                end
            end
            dag_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (cmd_reg == dag_pkg::CMD_CHECK)
                    begin
                        if (tbl_reg == dag_pkg::TBL_DEV && (container || !hit))
                        begin
                            state_next = dag_pkg::ST_SCAN;
                        end
                        else
                        begin
                            state_next = dag_pkg::ST_RESP;
                        end
                    end
                    else if (hit || (is_insert && free_avail))
                    begin
                        state_next = dag_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = dag_pkg::ST_RESP;
                    end
                end
            end
            dag_pkg::ST_WRITE:
            begin
                state_next = dag_pkg::ST_RESP;
            end
            dag_pkg::ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = dag_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dag_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        tbl_next        = tbl_reg;
        cmd_next        = cmd_reg;
        type_next       = type_reg;
        major_next      = major_reg;
        minor_next      = minor_reg;
        ns_next         = ns_reg;
        group_next      = group_reg;
        issue_next      = issue_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        d_found_next    = d_found_reg;
        d_owner_next    = d_owner_reg;
        wr_idx_next     = wr_idx_reg;
        wr_zero_next    = wr_zero_reg;
        res_allow_next  = res_allow_reg;
        res_status_next = res_status_reg;
        out_allow_next  = out_allow_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (state_reg)
            dag_pkg::ST_CLEAR:
            begin
                issue_next = issue_reg + CW'(1);
            end
            dag_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next   = dag_pkg::cmd_t'(s_tdata[2:0]);
                    type_next  = s_tdata[18:3];
                    major_next = s_tdata[30:19];
                    minor_next = s_tdata[50:31];
                    ns_next    = s_tdata[82:51];
                    group_next = s_tdata[146:83];
                end
            end
            dag_pkg::ST_DISPATCH:
            begin
                res_allow_next  = (cmd_reg == dag_pkg::CMD_CHECK) && early_allow;
                res_status_next = dag_pkg::STATUS_DONE;
                issue_next      = '0;
                free_found_next = 1'b0;
                case (cmd_reg)
                    dag_pkg::CMD_MARK, dag_pkg::CMD_UNMARK:  tbl_next = dag_pkg::TBL_MAJ;
                    dag_pkg::CMD_BIND, dag_pkg::CMD_UNBIND:  tbl_next = dag_pkg::TBL_NS;
                    default:                                 tbl_next = dag_pkg::TBL_DEV;
                endcase
            end
            dag_pkg::ST_SCAN:
            begin
                if (issue_reg < scan_len)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg;
                    issue_next   = issue_reg + CW'(1);
                end
                if (cmp_vld_reg && !sel_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (scan_end)
                begin
                    cmp_vld_next    = 1'b0;
                    issue_next      = '0;
                    free_found_next = 1'b0;
                    if (cmd_reg == dag_pkg::CMD_CHECK)
                    begin
                        case (tbl_reg)
                            dag_pkg::TBL_DEV:
                            begin
                                d_found_next = hit;
                                d_owner_next = sel_owner;
                                if (container)
                                begin
                                    tbl_next = dag_pkg::TBL_NS;
                                end
                                else if (hit)
                                begin
                                    res_allow_next = owner_eq;
                                end
                                else
                                begin
                                    tbl_next = dag_pkg::TBL_MAJ;
                                end
                            end
                            dag_pkg::TBL_NS:  res_allow_next = hit && d_found_reg && owner_eq;
                            default:          res_allow_next = !hit;
                        endcase
                    end
                    else if (hit)
                    begin
                        wr_idx_next  = cmp_idx_reg;
                        wr_zero_next = is_remove;
                    end
                    else if (is_insert && free_avail)
                    begin
                        wr_idx_next  = free_any_idx;
                        wr_zero_next = 1'b0;
                    end
                    else if (is_insert)
                    begin
                        res_status_next = dag_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res_status_next = dag_pkg::STATUS_ABSENT;
                    end
                end
            end
            dag_pkg::ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_allow_next  = res_allow_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Table write port: clearing pass after reset, else at most one write per table command.
    always_comb
    begin
        dev_we    = 1'b0;
        maj_we    = 1'b0;
        ns_we     = 1'b0;
        wr_addr   = wr_idx_reg;
        dev_wdata = wr_zero_reg ? 97'd0 : {1'b1, major_reg, minor_reg, group_reg};
        maj_wdata = wr_zero_reg ? 77'd0 : {1'b1, major_reg, group_reg};
        ns_wdata  = wr_zero_reg ? 97'd0 : {1'b1, ns_reg, group_reg};
        if (state_reg == dag_pkg::ST_CLEAR)
        begin
            wr_addr   = issue_reg;
            dev_wdata = '0;
            maj_wdata = '0;
            ns_wdata  = '0;
            dev_we    = (issue_reg < DEV_LEN);
            maj_we    = (issue_reg < MAJ_LEN);
            ns_we     = (issue_reg < NS_LEN);
        end
        else if (state_reg == dag_pkg::ST_WRITE)
        begin
            dev_we = (tbl_reg == dag_pkg::TBL_DEV);
            maj_we = (tbl_reg == dag_pkg::TBL_MAJ);
            ns_we  = (tbl_reg == dag_pkg::TBL_NS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dag_pkg::ST_CLEAR;
            issue_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            issue_reg    <= issue_next;
            cmp_vld_reg  <= cmp_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg        <= tbl_next;
        cmd_reg        <= cmd_next;
        type_reg       <= type_next;
        major_reg      <= major_next;
        minor_reg      <= minor_next;
        ns_reg         <= ns_next;
        group_reg      <= group_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        d_found_reg    <= d_found_next;
        d_owner_reg    <= d_owner_next;
        wr_idx_reg     <= wr_idx_next;
        wr_zero_reg    <= wr_zero_next;
        res_allow_reg  <= res_allow_next;
        res_status_reg <= res_status_next;
        out_allow_reg  <= out_allow_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_allow_reg};

    dag_ram #(.WIDTH(97), .DEPTH(DEV_ENTRIES)) u_dev_ram (
        .clk   (clk),
        .we    (dev_we),
        .waddr (wr_addr[AD-1:0]),
        .wdata (dev_wdata),
        .raddr (issue_reg[AD-1:0]),
        .rdata (dev_rdata)
    );

    dag_ram #(.WIDTH(77), .DEPTH(MAJOR_ENTRIES)) u_maj_ram (
        .clk   (clk),
        .we    (maj_we),
        .waddr (wr_addr[AM-1:0]),
        .wdata (maj_wdata),
        .raddr (issue_reg[AM-1:0]),
        .rdata (maj_rdata)
    );

    dag_ram #(.WIDTH(97), .DEPTH(NS_ENTRIES)) u_ns_ram (
        .clk   (clk),
        .we    (ns_we),
        .waddr (wr_addr[AN-1:0]),
        .wdata (ns_wdata),
        .raddr (issue_reg[AN-1:0]),
        .rdata (ns_rdata)
    );

    assign any_we   = dev_we || maj_we || ns_we;
    assign wr_phase = (state_reg == dag_pkg::ST_WRITE) || (state_reg == dag_pkg::ST_CLEAR);
    assign scan_cmp = (state_reg == dag_pkg::ST_SCAN) && cmp_vld_reg;

    `DAG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    `DAG_ASSERT_IMPL(a_cmp_in_range, scan_cmp, cmp_idx_reg < scan_len)
    `DAG_ASSERT_IMPL(a_write_state, any_we, wr_phase)
    `DAG_ASSERT_IMPL(a_status_no_allow, m_tvalid && m_tdata[2:1] != dag_pkg::STATUS_DONE, !m_tdata[0])

endmodule
`default_nettype wire

// File: tb/device_access_gate_tb.sv
// Self-checking testbench of the device access gate with a scoreboard that predicts each verdict.
`default_nettype none
module device_access_gate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_CYCLES = 1400;

    typedef struct
    {
        dag_pkg::cmd_t cmd;
        logic [15:0]   atype;
        logic [11:0]   major;
        logic [19:0]   minor;
        logic [31:0]   ns;
        logic [63:0]   group;
    } request_t;

    typedef struct
    {
        logic       allow;
        logic [1:0] status;
    } verdict_t;

    class verdict_board_t;
        logic [11:0] managed_major;
        logic [31:0] host_ns;
        logic [32:0] keys[3][1024];
        logic [63:0] owners[3][1024];
        int          depth[3];
        verdict_t    verdicts_due[$];
        int          errors;

        function new();
            depth = '{256, 256, 1024};
            managed_major = '0;
            host_ns = '0;
            errors = 0;
            foreach (keys[t, i])
            begin
                keys[t][i] = '0;
                owners[t][i] = '0;
            end
        endfunction

        function int lookup(dag_pkg::tbl_t t, logic [32:0] key, bit use_owner,
                            logic [63:0] owner);
            for (int i = 0; i < depth[t]; i++)
            begin
                if (keys[t][i] == key && (!use_owner || owners[t][i] == owner))
                    return i;
            end
            return -1;
        endfunction

        function logic [1:0] insert(dag_pkg::tbl_t t, logic [32:0] key, bit use_owner,
                                    logic [63:0] owner);
            int i;
            i = lookup(t, key, use_owner, owner);
            if (i < 0)
            begin
                for (int j = 0; j < depth[t]; j++)
                begin
                    if (keys[t][j] == '0)
                    begin
                        i = j;
                        break;
                    end
                end
            end
            if (i < 0)
                return dag_pkg::STATUS_FULL;
            keys[t][i] = key;
            owners[t][i] = owner;
            return dag_pkg::STATUS_DONE;
        endfunction

        function logic [1:0] remove(dag_pkg::tbl_t t, logic [32:0] key, bit use_owner,
                                    logic [63:0] owner);
            int i;
            i = lookup(t, key, use_owner, owner);
            if (i < 0)
                return dag_pkg::STATUS_ABSENT;
            keys[t][i] = '0;
            return dag_pkg::STATUS_DONE;
        endfunction

        function logic decide(request_t r);
            int d;
            int s;
            if (r.atype != dag_pkg::CHAR_DEVICE)
                return 1'b1;
            if (r.major == dag_pkg::SHARED_MAJOR && r.minor == dag_pkg::SHARED_MINOR)
                return 1'b1;
            if (r.major != dag_pkg::SHARED_MAJOR
                && (managed_major == 0 || r.major != managed_major))
                return 1'b1;
            d = lookup(dag_pkg::TBL_DEV, {1'b1, r.major, r.minor}, 0, '0);
            if (host_ns == 0 || r.ns != host_ns)
            begin
                s = lookup(dag_pkg::TBL_NS, {1'b1, r.ns}, 0, '0);
                if (s < 0)
                    return 1'b0;
                return d >= 0 && owners[dag_pkg::TBL_DEV][d] == owners[dag_pkg::TBL_NS][s];
            end
            if (d >= 0)
                return owners[dag_pkg::TBL_DEV][d] == r.group;
            if (lookup(dag_pkg::TBL_MAJ, {20'b0, 1'b1, r.major}, 1, r.group) >= 0)
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_request(request_t r);
            verdict_t v;
            logic [32:0] dkey;
            logic [32:0] mkey;
            logic [32:0] nkey;
            dkey = {1'b1, r.major, r.minor};
            mkey = {20'b0, 1'b1, r.major};
            nkey = {1'b1, r.ns};
            v.allow = 1'b0;
            v.status = dag_pkg::STATUS_DONE;
            case (r.cmd)
                dag_pkg::CMD_CHECK:   v.allow = decide(r);
                dag_pkg::CMD_RESERVE: v.status = insert(dag_pkg::TBL_DEV, dkey, 0, r.group);
                dag_pkg::CMD_RELEASE: v.status = remove(dag_pkg::TBL_DEV, dkey, 0, '0);
                dag_pkg::CMD_MARK:    v.status = insert(dag_pkg::TBL_MAJ, mkey, 1, r.group);
                dag_pkg::CMD_UNMARK:  v.status = remove(dag_pkg::TBL_MAJ, mkey, 1, r.group);
                dag_pkg::CMD_BIND:    v.status = insert(dag_pkg::TBL_NS, nkey, 0, r.group);
                dag_pkg::CMD_UNBIND:  v.status = remove(dag_pkg::TBL_NS, nkey, 0, '0);
                default:              ;
            endcase
            verdicts_due.push_back(v);
        endfunction

        function void check_verdict(logic [7:0] word);
            verdict_t v;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            v = verdicts_due.pop_front();
            if (word[0] !== v.allow)
            begin
                $display("%0t: allow expected %0d actual %0d", $time, v.allow, word[0]);
                errors++;
            end
            if (word[2:1] !== v.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, v.status, word[2:1]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // cmd, dev_type, major, minor, mnt_ns, group_id, zero fill.
    logic [151:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // allow, status, zero fill.
    logic [7:0]   m_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    verdict_board_t board;
    int  burst_left;
    bit  hold_req;
    int  cycles;

    device_access_gate i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        request_t r;
        forever
        begin
            @(posedge clk);
            if (rst_n && s_tvalid && s_tready)
            begin
                r.cmd   = dag_pkg::cmd_t'(s_tdata[2:0]);
                r.atype = s_tdata[18:3];
                r.major = s_tdata[30:19];
                r.minor = s_tdata[50:31];
                r.ns    = s_tdata[82:51];
                r.group = s_tdata[146:83];
                board.note_request(r);
            end
            if (rst_n && m_tvalid && m_tready)
                board.check_verdict(m_tdata);
        end
    end

    initial
    begin
        int mode;
        m_tready = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == {dag_pkg::ADDR_MANAGED_MAJOR, 2'b00})
            board.managed_major = value[11:0];
        else
            board.host_ns = value;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(logic [11:0] managed, logic [31:0] host);
        write_register({dag_pkg::ADDR_MANAGED_MAJOR, 2'b00}, {20'b0, managed});
        write_register({dag_pkg::ADDR_HOST_MNT_NS, 2'b00}, host);
    endtask

    task automatic send(request_t r);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tdata = {5'b0, r.group, r.ns, r.minor, r.major, r.atype, r.cmd};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_fields(dag_pkg::cmd_t c, logic [15:0] at, logic [11:0] mj,
                               logic [19:0] mn, logic [31:0] ns, logic [63:0] grp);
        request_t r;
        r = '{c, at, mj, mn, ns, grp};
        send(r);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        burst_left = 0;
        while (board.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random(int count);
        request_t r;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.cmd = dag_pkg::CMD_CHECK;
            else if (pick < 60)
                r.cmd = dag_pkg::CMD_RESERVE;
            else if (pick < 68)
                r.cmd = dag_pkg::CMD_RELEASE;
            else if (pick < 76)
                r.cmd = dag_pkg::CMD_MARK;
            else if (pick < 84)
                r.cmd = dag_pkg::CMD_UNMARK;
            else if (pick < 92)
                r.cmd = dag_pkg::CMD_BIND;
            else if (pick < 98)
                r.cmd = dag_pkg::CMD_UNBIND;
            else
                r.cmd = dag_pkg::CMD_NONE;
            r.atype = ($urandom_range(0, 7) == 0) ? 16'($urandom) : dag_pkg::CHAR_DEVICE;
            case ($urandom_range(0, 7))
                0, 1, 2: r.major = board.managed_major;
                3, 4:    r.major = dag_pkg::SHARED_MAJOR;
                5:       r.major = 12'($urandom);
                default: r.major = 12'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 7))
                0:       r.minor = dag_pkg::SHARED_MINOR;
                1:       r.minor = 20'($urandom);
                2:       r.minor = 20'hFFFFF;
                default: r.minor = 20'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2: r.ns = board.host_ns;
                3:       r.ns = $urandom;
                4:       r.ns = 32'hFFFFFFFF;
                default: r.ns = $urandom_range(1, 3);
            endcase
            case ($urandom_range(0, 7))
                0:       r.group = {$urandom, $urandom};
                1:       r.group = '1;
                default: r.group = 64'($urandom_range(1, 3));
            endcase
            send(r);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        hold_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        configure(12'd10, 32'd100);
        send_fields(dag_pkg::CMD_CHECK, 16'd1, 12'd10, 20'd3, 32'd100, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, 16'hFFFF, 12'd10, 20'd3, 32'd100, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, dag_pkg::SHARED_MAJOR,
                    dag_pkg::SHARED_MINOR, 32'd7, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd5, 20'd3, 32'd7, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd100, 64'd1);
        send_fields(dag_pkg::CMD_MARK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd0, 32'd0, 64'd1);
        send_fields(dag_pkg::CMD_MARK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd0, 32'd0, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd100, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd100, 64'd2);
        send_fields(dag_pkg::CMD_RESERVE, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd0, 64'd1);
        send_fields(dag_pkg::CMD_RESERVE, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd0, 64'd2);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd100, 64'd2);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd100, 64'd1);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd50, 64'd2);
        send_fields(dag_pkg::CMD_BIND, dag_pkg::CHAR_DEVICE, 12'd0, 20'd0, 32'd50, 64'd2);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd50, 64'd9);
        send_fields(dag_pkg::CMD_CHECK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd4, 32'd50, 64'd9);
        send_fields(dag_pkg::CMD_RELEASE, dag_pkg::CHAR_DEVICE, 12'd10, 20'd4, 32'd0, 64'd0);
        send_fields(dag_pkg::CMD_RELEASE, dag_pkg::CHAR_DEVICE, 12'd10, 20'd3, 32'd0, 64'd0);
        send_fields(dag_pkg::CMD_UNBIND, dag_pkg::CHAR_DEVICE, 12'd0, 20'd0, 32'd50, 64'd0);
        send_fields(dag_pkg::CMD_UNBIND, dag_pkg::CHAR_DEVICE, 12'd0, 20'd0, 32'd50, 64'd0);
        send_fields(dag_pkg::CMD_UNMARK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd0, 32'd0, 64'd2);
        send_fields(dag_pkg::CMD_UNMARK, dag_pkg::CHAR_DEVICE, 12'd10, 20'd0, 32'd0, 64'd1);
        send_fields(dag_pkg::CMD_NONE, 16'hFFFF, 12'hFFF, 20'hFFFFF, 32'hFFFFFFFF, '1);
        drain();

        // With no host namespace every requester counts as a container requester.
        configure(12'd0, 32'd0);
        for (int i = 0; i <= 256; i++)
            send_fields(dag_pkg::CMD_MARK, dag_pkg::CHAR_DEVICE, 12'(i), 20'd0, 32'd0,
                        {$urandom, $urandom});
        send_random(30);
        drain();

        configure(12'hFFF, 32'hFFFFFFFF);
        send_random(10);
        hold_req = 1'b1;
        send_random(30);
        drain();

        configure(dag_pkg::SHARED_MAJOR, $urandom);
        send_random(25);
        drain();

        if (board.errors == 0 && board.verdicts_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
